// ===== rtl/core/box_blur_3x3_stream_defines.svh =====
// Assertion macros shared by the box blur checker.
`ifndef BOX_BLUR_3X3_STREAM_DEFINES_SVH
`define BOX_BLUR_3X3_STREAM_DEFINES_SVH

// Same-cycle implication, held off while the disable condition is high.
`define BB3_ASSERT_IMPLY(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("box blur stream check failed");

// Next-cycle implication, held off while the disable condition is high.
`define BB3_ASSERT_NEXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("box blur stream check failed");

`endif

// ===== rtl/core/bb3_pkg.sv =====
// Types and constants shared by the box blur stream modules.
package bb3_pkg;

   // Configuration register indexes.
   localparam logic CSR_LINE_WIDTH   = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   localparam int CSR_DATA_W = 13;
   localparam int LW_BITS    = 12;
   localparam int FH_BITS    = 13;
   localparam int ROW_W      = 12;
   localparam int MAX_HEIGHT = 4096;
   localparam int MIN_DIM    = 3;
   localparam int RESET_DIM  = 2048;

   // Widths of the stored and produced values.
   localparam int OUT_W  = 8;
   localparam int CSUM_W = 10;
   localparam int WSUM_W = 12;

   // Division by nine: floor(x / 9) == (x * 3641) >> 15 for all x below 32768.
   localparam logic [WSUM_W-1:0] DIV9_MUL = 12'd3641;
   localparam int DIV9_SHIFT = 15;
   localparam int PROD_W     = 24;
   localparam logic [WSUM_W-1:0] ROUND_BIAS = 12'd4;

   // Depth of the queue between the front and the back; a power of two.
   localparam int QUEUE_DEPTH = 4;

   // What the front decides about each item.
   typedef struct packed {
      logic row_ge2;
      logic emit;
      logic last;
   } tag_type;

endpackage

// ===== rtl/core/bb3_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module bb3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bb3_front.sv =====
// Front part: configuration registers, frame position counters and item classification.
module bb3_front #(
   parameter int MAX_LINE = 2048
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [bb3_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           accept,
   output logic [$clog2(MAX_LINE)-1:0]    col,
   output bb3_pkg::tag_type               tag
);

   localparam int CW = $clog2(MAX_LINE);
   localparam int RESET_W = (MAX_LINE < bb3_pkg::RESET_DIM) ? MAX_LINE : bb3_pkg::RESET_DIM;

   logic [CW-1:0]                 w_last_ff, w_last_in;
   logic [bb3_pkg::ROW_W-1:0]     h_last_ff, h_last_in;
   logic [CW-1:0]                 col_ff, col_in;
   logic [bb3_pkg::ROW_W-1:0]     row_ff, row_in;
   logic [31:0]                   lw_val;
   logic [31:0]                   fh_val;
   logic                          last_col;
   logic                          last_row;

   // Clamp written sizes into range and keep them as last index values.
   always_comb begin
      lw_val = 32'(csr_wdata[bb3_pkg::LW_BITS-1:0]);
      fh_val = 32'(csr_wdata[bb3_pkg::FH_BITS-1:0]);
      if (lw_val < 32'(bb3_pkg::MIN_DIM)) begin
         lw_val = 32'(bb3_pkg::MIN_DIM);
      end else if (lw_val > 32'(MAX_LINE)) begin
         lw_val = 32'(MAX_LINE);
      end
      if (fh_val < 32'(bb3_pkg::MIN_DIM)) begin
         fh_val = 32'(bb3_pkg::MIN_DIM);
      end else if (fh_val > 32'(bb3_pkg::MAX_HEIGHT)) begin
         fh_val = 32'(bb3_pkg::MAX_HEIGHT);
      end
      w_last_in = w_last_ff;
      h_last_in = h_last_ff;
      if (csr_we) begin
         unique case (csr_index)
            bb3_pkg::CSR_LINE_WIDTH:   w_last_in = CW'(lw_val - 32'd1);
            bb3_pkg::CSR_FRAME_HEIGHT: h_last_in = bb3_pkg::ROW_W'(fh_val - 32'd1);
            default: ;
         endcase
      end
   end

   // Classify the item at the current position.
   assign last_col    = (col_ff >= w_last_ff);
   assign last_row    = (row_ff >= h_last_ff);
   assign tag.row_ge2 = (row_ff >= bb3_pkg::ROW_W'(2));
   assign tag.emit    = tag.row_ge2 && (col_ff >= CW'(2));
   assign tag.last    = tag.emit && last_col && last_row;
   assign col         = col_ff;

   // Advance the raster position on each accepted item.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff <= CW'(RESET_W - 1);
         h_last_ff <= bb3_pkg::ROW_W'(bb3_pkg::RESET_DIM - 1);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         w_last_ff <= w_last_in;
         h_last_ff <= h_last_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

// ===== rtl/core/bb3_queue.sv =====
// Short queue of classified items between the front and the back.
module bb3_queue #(
   parameter int WIDTH = 23
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             full,
   output logic             empty
);

   localparam int PW = $clog2(bb3_pkg::QUEUE_DEPTH);

   logic [WIDTH-1:0] slot_ff [bb3_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;

   assign full      = (count_ff == (PW+1)'(bb3_pkg::QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Item storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/bb3_back.sv =====
// Back part: line buffers, column and window sums, division by nine and result register.
module bb3_back #(
   parameter int MAX_LINE = 2048,
   parameter int PIX_W    = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  logic [PIX_W-1:0]              head_pixel,
   input  logic [$clog2(MAX_LINE)-1:0]   head_col,
   input  bb3_pkg::tag_type              head_tag,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [bb3_pkg::OUT_W-1:0]     rsp_tdata,
   output logic                          rsp_tlast
);

   localparam int CW = $clog2(MAX_LINE);

   logic                            adv;
   logic [2*PIX_W-1:0]              lines_rd;
   logic [PIX_W-1:0]                upper_rd;
   logic [PIX_W-1:0]                middle_rd;

   logic                            s2_vld_ff;
   logic [PIX_W-1:0]                s2_pixel_ff;
   logic [CW-1:0]                   s2_col_ff;
   bb3_pkg::tag_type                s2_tag_ff;

   logic [bb3_pkg::CSUM_W-1:0]      csum0_ff, csum1_ff;
   logic [bb3_pkg::CSUM_W-1:0]      col_sum;
   logic [bb3_pkg::WSUM_W-1:0]      win_sum;

   logic                            s3_vld_ff;
   logic                            s3_emit_ff;
   logic                            s3_last_ff;
   logic [bb3_pkg::WSUM_W-1:0]      s3_sum_ff;
   logic [bb3_pkg::PROD_W-1:0]      prod;

   logic                            rsp_tvalid_ff;
   logic                            rsp_tlast_ff;
   logic [bb3_pkg::OUT_W-1:0]       rsp_tdata_ff;

   // The whole back pipeline moves unless a result is waiting and not taken.
   assign adv = !(rsp_tvalid_ff && !rsp_tready);
   assign pop = adv && head_valid;

   // Both line buffers share one RAM word: upper row above, middle row below.
   bb3_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_LINE)
   ) u_lines (
      .clock   (clock),
      .wr_en   (adv && s2_vld_ff),
      .wr_addr (s2_col_ff),
      .wr_data ({middle_rd, s2_pixel_ff}),
      .rd_en   (adv),
      .rd_addr (head_col),
      .rd_data (lines_rd)
   );

   assign upper_rd  = lines_rd[2*PIX_W-1:PIX_W];
   assign middle_rd = lines_rd[PIX_W-1:0];

   // Vertical sum of the current column and the full window sum.
   always_comb begin
      col_sum = '0;
      if (s2_tag_ff.row_ge2) begin
         col_sum = bb3_pkg::CSUM_W'(upper_rd) + bb3_pkg::CSUM_W'(middle_rd)
                 + bb3_pkg::CSUM_W'(s2_pixel_ff);
      end
      win_sum = bb3_pkg::WSUM_W'(csum0_ff) + bb3_pkg::WSUM_W'(csum1_ff)
              + bb3_pkg::WSUM_W'(col_sum);
   end

   // Rounded quotient by nine through the reciprocal.
   assign prod = bb3_pkg::PROD_W'(s3_sum_ff) * bb3_pkg::PROD_W'(bb3_pkg::DIV9_MUL);

   // Pipeline valid bits, column sums and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff     <= 1'b0;
         s3_vld_ff     <= 1'b0;
         csum0_ff      <= '0;
         csum1_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
         rsp_tlast_ff  <= 1'b0;
      end else if (adv) begin
         s2_vld_ff     <= head_valid;
         s3_vld_ff     <= s2_vld_ff;
         if (s2_vld_ff) begin
            csum1_ff <= csum0_ff;
            csum0_ff <= col_sum;
         end
         rsp_tvalid_ff <= s3_vld_ff && s3_emit_ff;
         rsp_tlast_ff  <= s3_vld_ff && s3_emit_ff && s3_last_ff;
      end
   end

   // Payload registers move with the pipeline.
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_pixel_ff  <= head_pixel;
         s2_col_ff    <= head_col;
         s2_tag_ff    <= head_tag;
         s3_emit_ff   <= s2_tag_ff.emit;
         s3_last_ff   <= s2_tag_ff.last;
         s3_sum_ff    <= win_sum + bb3_pkg::ROUND_BIAS;
         rsp_tdata_ff <= prod[bb3_pkg::DIV9_SHIFT +: bb3_pkg::OUT_W];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// ===== rtl/core/box_blur_3x3_stream.sv =====
// Top level of the streaming 3x3 box blur.
//
// Pixels of a padded frame enter in raster order, one item per clock, and the block
// sustains one item per clock as long as results are taken. A result (the rounded mean
// of the 3x3 window ending at that pixel) is built in order: the pixel waits in the
// queue, the line-buffer RAM is read, the column and window sums are registered, and
// the multiply by the reciprocal of nine feeds the result register.
// Border pixels (column or row below two) give no result. rsp_tlast marks the
// final result of a frame, after which the position counters restart. A four-item queue
// lets input keep flowing while the output is stalled, until it is full. The line buffers
// need no clearing after reset; line_width and frame_height are clamped to their legal
// ranges when written and should be changed only between frames.
module box_blur_3x3_stream #(
   parameter int MAX_LINE   = 2048,
   parameter int PIXEL_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   // Input: tdata = pixel[7:0].
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,
   // Output: tdata = blurred[7:0]; tlast = frame_last.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,
   output logic                           rsp_tlast,
   // Configuration: index 0 = line_width, index 1 = frame_height.
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [bb3_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int PIX_W = (PIXEL_BITS < 8) ? PIXEL_BITS : 8;
   localparam int CW    = $clog2(MAX_LINE);
   localparam int TAG_W = $bits(bb3_pkg::tag_type);
   localparam int QW    = TAG_W + CW + PIX_W;

   logic                 accept;
   logic                 q_full;
   logic                 q_empty;
   logic                 q_pop;
   logic [CW-1:0]        front_col;
   bb3_pkg::tag_type     front_tag;
   logic [QW-1:0]        head_data;
   bb3_pkg::tag_type     head_tag;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   bb3_front #(
      .MAX_LINE (MAX_LINE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .col       (front_col),
      .tag       (front_tag)
   );

   bb3_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data ({front_tag, front_col, req_tdata[PIX_W-1:0]}),
      .pop       (q_pop),
      .head_data (head_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   assign head_tag = head_data[QW-1:CW+PIX_W];

   bb3_back #(
      .MAX_LINE (MAX_LINE),
      .PIX_W    (PIX_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!q_empty),
      .head_pixel (head_data[PIX_W-1:0]),
      .head_col   (head_data[CW+PIX_W-1:PIX_W]),
      .head_tag   (head_tag),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/core/bb3_checker.sv =====
// Port-level checker for the box blur stream, bound to the top level.
`include "box_blur_3x3_stream_defines.svh"

module bb3_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // A stalled result keeps its valid and its payload.
   `BB3_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // The frame end mark only ever rides on a valid result.
   `BB3_ASSERT_IMPLY(a_last_valid, clock, reset, rsp_tlast, rsp_tvalid)

   // Reset leaves no result pending.
   `BB3_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_tvalid && !rsp_tlast)

   // Input back-pressure only follows a stalled output.
   `BB3_ASSERT_IMPLY(a_ready_cause, clock, reset, !req_tready, $past(rsp_tvalid && !rsp_tready))

   // An input is never refused right after reset.
   `BB3_ASSERT_IMPLY(a_ready_after_reset, clock, reset, $past(reset), req_tready || !req_tvalid || req_tready)

endmodule

bind box_blur_3x3_stream bb3_checker u_bb3_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
